/* design/mts_pkg.sv */
// Package for the mixing tank step block: register map, reset values and the
// request/response types shared by the sequencer and the iterative divider.
// No dependencies.
`default_nettype none

package mts_pkg;

    localparam int unsigned ADDR_W = 3;

    // Register index as decoded from paddr[2].
    localparam logic REG_MAX_VOLUME = 1'b0;
    localparam logic REG_TIME_STEP  = 1'b1;

    localparam logic [31:0] MAX_VOLUME_RESET = 32'd6553600;  // 100.0 in Q16.16
    localparam logic [31:0] TIME_STEP_RESET  = 32'd65536;    // 1.0 in Q16.16
    localparam logic [31:0] SIGN_OFFSET      = 32'h8000_0000;
    localparam int unsigned FRAC_BITS        = 16;

    // One quotient bit per cycle; the quotient always fits in 32 bits.
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* design/mts_if.sv */
// Channel interfaces for the mixing tank step block: one for the input
// transactions and one for the result transactions. No dependencies.
`default_nettype none

interface mts_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] inflow_rate;
    logic signed [31:0] inflow_temperature;
    logic        [31:0] inflow_conc_a;
    logic        [31:0] inflow_conc_b;

    modport source (output valid, inflow_rate, inflow_temperature, inflow_conc_a,
                    inflow_conc_b, input ready);
    modport sink (input valid, inflow_rate, inflow_temperature, inflow_conc_a,
                  inflow_conc_b, output ready);
endinterface

interface mts_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] tank_volume;
    logic signed [31:0] tank_temperature;
    logic        [31:0] tank_conc_a;
    logic        [31:0] tank_conc_b;
    logic               overflow;

    modport source (output valid, tank_volume, tank_temperature, tank_conc_a,
                    tank_conc_b, overflow, input ready);
    modport sink (input valid, tank_volume, tank_temperature, tank_conc_a,
                  tank_conc_b, overflow, output ready);
endinterface

`default_nettype wire

/* design/mts_div.sv */
// Iterative restoring divider, one quotient bit per cycle, for 64 by 32 bit
// divisions whose quotient is known to fit in 32 bits. Depends on mts_pkg.
`default_nettype none

module mts_div
    import mts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [31:0]          rem_reg;
    logic [31:0]          low_reg;   // dividend low bits, then quotient bits
    logic [31:0]          den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        q_bit;

    assign trial = {rem_reg, low_reg[31]};
    assign diff  = trial - {1'b0, den_reg};
    assign q_bit = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            low_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                // The high half is below the divisor, so it is a valid remainder.
                rem_reg  <= req.dividend[63:32];
                low_reg  <= req.dividend[31:0];
                den_reg  <= req.divisor;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= q_bit ? diff[31:0] : trial[31:0];
                low_reg <= {low_reg[30:0], q_bit};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = low_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("divider did not go busy after start");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && !$past(done_reg))
        else $error("divider done overlaps a running division");

endmodule

`default_nettype wire

/* design/mixing_tank_step.sv */
// Mixing tank step: one time step of a perfectly mixed tank in Q16.16.
// Depends on mts_pkg, mts_in_if, mts_out_if and mts_div.
//
// Each input transaction on step_in carries an inflow rate, temperature and two
// solute concentrations. A positive rate times time_step gives the incoming volume;
// temperature and both concentrations become volume-weighted averages and the
// volume grows, saturating at all ones. Every input gives one result transaction on
// step_out with the new tank state and an overflow flag (volume above max_volume).
// The two registers are written over the APB port at byte addresses 0 and 4.
//
// When the tank is updated, the sequencer works through the three weighted averages,
// each of which takes two passes through the one shared 32x32 multiplier and one
// run of the bit-serial divider; a step that changes nothing skips them.
// step_in.ready is high only while the sequencer is idle, so a new input is taken
// only once the sequencer is through with the last one.
// The result sits in an output register; the next input is taken while it waits,
// and the sequencer holds its finished result until step_out is free.
// Reset clears the tank state to zero and loads max_volume = 100.0, time_step = 1.0.
`default_nettype none

module mixing_tank_step
    import mts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    mts_in_if.sink                 step_in,
    mts_out_if.source              step_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_INC,
        ST_CHECK,
        ST_MUL_OLD,
        ST_MUL_IN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MIX_TEMP,
        MIX_A,
        MIX_B
    } mix_t;

    state_t      state_reg;
    mix_t        mix_reg;

    logic [31:0] max_volume_reg;
    logic [31:0] time_step_reg;

    logic [31:0] volume_reg;
    logic [31:0] temperature_reg;
    logic [31:0] conc_a_reg;
    logic [31:0] conc_b_reg;

    logic [31:0] rate_reg;
    logic [31:0] in_temp_reg;
    logic [31:0] in_a_reg;
    logic [31:0] in_b_reg;

    logic [31:0] w_tank_reg;
    logic [31:0] w_in_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;

    logic        out_valid_reg;
    logic [31:0] out_volume_reg;
    logic [31:0] out_temp_reg;
    logic [31:0] out_a_reg;
    logic [31:0] out_b_reg;
    logic        out_overflow_reg;

    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] product;
    logic [31:0] inc;
    logic [32:0] sum;
    logic        rate_pos;
    logic [31:0] old_val;
    logic [31:0] in_val;
    logic        cfg_write;
    logic        out_free;

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_MAX_VOLUME: prdata = max_volume_reg;
            REG_TIME_STEP:  prdata = time_step_reg;
            default:        prdata = max_volume_reg;
        endcase
    end

    // Operand selection for the averaged quantity; temperature is offset so the
    // unsigned floor division rounds toward minus infinity.
    always_comb
    begin
        case (mix_reg)
            MIX_TEMP:
            begin
                old_val = temperature_reg ^ SIGN_OFFSET;
                in_val  = in_temp_reg ^ SIGN_OFFSET;
            end
            MIX_A:
            begin
                old_val = conc_a_reg;
                in_val  = in_a_reg;
            end
            MIX_B:
            begin
                old_val = conc_b_reg;
                in_val  = in_b_reg;
            end
            default:
            begin
                old_val = conc_b_reg;
                in_val  = in_b_reg;
            end
        endcase
    end

    // The shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_MUL_INC:
            begin
                mul_x = rate_reg;
                mul_y = time_step_reg;
            end
            ST_MUL_OLD:
            begin
                mul_x = old_val;
                mul_y = w_tank_reg;
            end
            default:
            begin
                mul_x = in_val;
                mul_y = w_in_reg;
            end
        endcase
    end

    assign product  = {32'd0, mul_x} * {32'd0, mul_y};
    assign inc      = (prod_reg[63:48] != '0) ? 32'hFFFF_FFFF : prod_reg[47:FRAC_BITS];
    assign sum      = {1'b0, volume_reg} + {1'b0, inc};
    assign rate_pos = !rate_reg[31] && (rate_reg != '0);

    assign div_req.start    = (state_reg == ST_DIV_START);
    assign div_req.dividend = acc_reg + prod_reg;
    assign div_req.divisor  = w_tank_reg + w_in_reg;

    mts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free = !out_valid_reg || step_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mix_reg          <= MIX_TEMP;
            max_volume_reg   <= MAX_VOLUME_RESET;
            time_step_reg    <= TIME_STEP_RESET;
            volume_reg       <= '0;
            temperature_reg  <= '0;
            conc_a_reg       <= '0;
            conc_b_reg       <= '0;
            rate_reg         <= '0;
            in_temp_reg      <= '0;
            in_a_reg         <= '0;
            in_b_reg         <= '0;
            w_tank_reg       <= '0;
            w_in_reg         <= '0;
            prod_reg         <= '0;
            acc_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_volume_reg   <= '0;
            out_temp_reg     <= '0;
            out_a_reg        <= '0;
            out_b_reg        <= '0;
            out_overflow_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[2])
                    REG_MAX_VOLUME: max_volume_reg <= pwdata;
                    REG_TIME_STEP:  time_step_reg  <= pwdata;
                    default:        max_volume_reg <= pwdata;
                endcase
            end

            // A new result takes the output register as the old one leaves it.
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (step_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (step_in.valid)
                    begin
                        rate_reg    <= step_in.inflow_rate;
                        in_temp_reg <= step_in.inflow_temperature;
                        in_a_reg    <= step_in.inflow_conc_a;
                        in_b_reg    <= step_in.inflow_conc_b;
                        state_reg   <= ST_MUL_INC;
                    end
                end
                ST_MUL_INC:
                begin
                    prod_reg  <= product;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (rate_pos && (inc != '0))
                    begin
                        // Halve both weights when their sum would not fit.
                        w_tank_reg <= sum[32] ? {1'b0, volume_reg[31:1]} : volume_reg;
                        w_in_reg   <= sum[32] ? {1'b0, inc[31:1]} : inc;
                        volume_reg <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        mix_reg    <= MIX_TEMP;
                        state_reg  <= ST_MUL_OLD;
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_MUL_OLD:
                begin
                    acc_reg   <= product;
                    state_reg <= ST_MUL_IN;
                end
                ST_MUL_IN:
                begin
                    prod_reg  <= product;
                    state_reg <= ST_DIV_START;
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        case (mix_reg)
                            MIX_TEMP:
                            begin
                                temperature_reg <= div_rsp.quotient ^ SIGN_OFFSET;
                                mix_reg         <= MIX_A;
                                state_reg       <= ST_MUL_OLD;
                            end
                            MIX_A:
                            begin
                                conc_a_reg <= div_rsp.quotient;
                                mix_reg    <= MIX_B;
                                state_reg  <= ST_MUL_OLD;
                            end
                            default:
                            begin
                                conc_b_reg <= div_rsp.quotient;
                                state_reg  <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_volume_reg   <= volume_reg;
                        out_temp_reg     <= temperature_reg;
                        out_a_reg        <= conc_a_reg;
                        out_b_reg        <= conc_b_reg;
                        out_overflow_reg <= (volume_reg > max_volume_reg);
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign step_in.ready             = (state_reg == ST_IDLE);
    assign step_out.valid            = out_valid_reg;
    assign step_out.tank_volume      = out_volume_reg;
    assign step_out.tank_temperature = out_temp_reg;
    assign step_out.tank_conc_a      = out_a_reg;
    assign step_out.tank_conc_b      = out_b_reg;
    assign step_out.overflow         = out_overflow_reg;

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result transaction raised outside the finish step");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV_WAIT)
        else $error("division finished while the sequencer was not waiting");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !step_out.ready |=>
            out_valid_reg && $stable(out_volume_reg) && $stable(out_overflow_reg))
        else $error("stalled result transaction changed before it was taken");

endmodule

`default_nettype wire

/* dv/mixing_tank_step_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for mixing_tank_step: drives tank steps and APB register
// writes, predicts each reported tank state and compares it field by field.
// Depends on mts_pkg, mts_in_if, mts_out_if and the mixing_tank_step RTL.

module mixing_tank_step_tb;
    import mts_pkg::*;

    localparam int TAIL_CYCLES      = 200;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int DRAIN_LIMIT      = 50000;

    typedef struct packed {
        logic signed [31:0] rate;
        logic signed [31:0] temp;
        logic        [31:0] conc_a;
        logic        [31:0] conc_b;
    } inflow_t;

    typedef struct packed {
        logic        [31:0] volume;
        logic signed [31:0] temperature;
        logic        [31:0] conc_a;
        logic        [31:0] conc_b;
        logic               overflow;
    } tank_state_t;

    class tank_scoreboard;
        logic        [31:0] max_vol;
        logic        [31:0] step_len;
        logic        [31:0] volume;
        logic signed [31:0] temperature;
        logic        [31:0] conc_a;
        logic        [31:0] conc_b;
        tank_state_t        predicted_states[$];
        int unsigned        errors;
        int unsigned        steps;
        int unsigned        mixed_steps;
        int unsigned        overflow_steps;

        function new();
            max_vol        = MAX_VOLUME_RESET;
            step_len       = TIME_STEP_RESET;
            volume         = '0;
            temperature    = '0;
            conc_a         = '0;
            conc_b         = '0;
            errors         = 0;
            steps          = 0;
            mixed_steps    = 0;
            overflow_steps = 0;
        endfunction

        function void load_register(logic idx, logic [31:0] value);
            if (idx == REG_MAX_VOLUME)
                max_vol = value;
            else
                step_len = value;
        endfunction

        function int pending();
            return predicted_states.size();
        endfunction

        // Floor of the weighted average. The weights never sum to zero when this is called.
        function logic [31:0] blend(logic [31:0] a, logic [31:0] wa,
                                    logic [31:0] b, logic [31:0] wb);
            logic [63:0] num;
            logic [63:0] den;
            logic [63:0] quo;
            num = {32'd0, a} * {32'd0, wa} + {32'd0, b} * {32'd0, wb};
            den = {32'd0, wa} + {32'd0, wb};
            quo = num / den;
            return quo[31:0];
        endfunction

        function void note_inflow(inflow_t it);
            logic [63:0] scaled;
            logic [31:0] inc;
            logic [31:0] w_tank;
            logic [31:0] w_in;
            logic [32:0] sum;
            tank_state_t want;
            steps++;
            inc = '0;
            if (!it.rate[31] && it.rate != 0)
            begin
                scaled = ({32'd0, it.rate} * {32'd0, step_len}) >> FRAC_BITS;
                inc = (scaled[63:32] != 0) ? 32'hFFFF_FFFF : scaled[31:0];
            end
            if (inc != 0)
            begin
                mixed_steps++;
                sum = {1'b0, volume} + {1'b0, inc};
                // When the combined volume no longer fits, both weights lose one bit.
                w_tank = sum[32] ? volume >> 1 : volume;
                w_in   = sum[32] ? inc >> 1 : inc;
                // The temperature is averaged in offset binary so the rounding is a floor.
                temperature = blend(temperature ^ SIGN_OFFSET, w_tank,
                                    it.temp ^ SIGN_OFFSET, w_in) ^ SIGN_OFFSET;
                conc_a = blend(conc_a, w_tank, it.conc_a, w_in);
                conc_b = blend(conc_b, w_tank, it.conc_b, w_in);
                volume = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            want.volume      = volume;
            want.temperature = temperature;
            want.conc_a      = conc_a;
            want.conc_b      = conc_b;
            want.overflow    = (volume > max_vol);
            if (want.overflow)
                overflow_steps++;
            predicted_states = {predicted_states, want};
        endfunction

        function void check_result(tank_state_t got);
            tank_state_t want;
            if (predicted_states.size() == 0)
            begin
                $error("tank state transaction arrived with no step outstanding");
                errors++;
                return;
            end
            want = predicted_states.pop_front();
            if (got.volume !== want.volume)
            begin
                $error("tank_volume: expected %h, got %h", want.volume, got.volume);
                errors++;
            end
            if (got.temperature !== want.temperature)
            begin
                $error("tank_temperature: expected %h, got %h",
                       want.temperature, got.temperature);
                errors++;
            end
            if (got.conc_a !== want.conc_a)
            begin
                $error("tank_conc_a: expected %h, got %h", want.conc_a, got.conc_a);
                errors++;
            end
            if (got.conc_b !== want.conc_b)
            begin
                $error("tank_conc_b: expected %h, got %h", want.conc_b, got.conc_b);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %b, got %b", want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    bit             long_hold_go;
    int unsigned    reg_writes;
    tank_scoreboard sb;

    mts_in_if  step_in_if ();
    mts_out_if step_out_if ();

    mixing_tank_step dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .step_in  (step_in_if),
        .step_out (step_out_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic inflow_t inflow_of(logic [31:0] rate, logic [31:0] temp,
                                          logic [31:0] conc_a, logic [31:0] conc_b);
        inflow_t it;
        it.rate   = rate;
        it.temp   = temp;
        it.conc_a = conc_a;
        it.conc_b = conc_b;
        return it;
    endfunction

    // Mostly positive rates in the given range, with some zero and negative rates mixed in.
    function automatic inflow_t random_inflow(int unsigned rate_lo, int unsigned rate_hi);
        inflow_t     it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6)
            it.rate = '0;
        else if (pick < 12)
            it.rate = $urandom() | 32'h8000_0000;
        else
            it.rate = $urandom_range(rate_hi, rate_lo);
        pick = $urandom_range(19);
        if (pick == 0)
            it.temp = 32'h7FFF_FFFF;
        else if (pick == 1)
            it.temp = 32'h8000_0000;
        else
            it.temp = $urandom();
        it.conc_a = (pick == 2) ? 32'hFFFF_FFFF : $urandom();
        it.conc_b = (pick == 3) ? 32'h0000_0000 : $urandom();
        return it;
    endfunction

    task automatic send_step(input inflow_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            step_in_if.valid <= 1'b0;
            @(posedge clk);
        end
        step_in_if.valid              <= 1'b1;
        step_in_if.inflow_rate        <= it.rate;
        step_in_if.inflow_temperature <= it.temp;
        step_in_if.inflow_conc_a      <= it.conc_a;
        step_in_if.inflow_conc_b      <= it.conc_b;
        do
            @(posedge clk);
        while (!step_in_if.ready);
        sb.note_inflow(it);
    endtask

    task automatic run_random(int count, int unsigned rate_lo, int unsigned rate_hi);
        repeat (count)
            send_step(random_inflow(rate_lo, rate_hi));
    endtask

    task automatic settle_tank();
        step_in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only with the tank idle; each write is read back.
    task automatic set_register(input logic idx, input logic [31:0] value);
        logic [31:0] rdata;
        settle_tank();
        apb_access(1'b1, {idx, 2'b00}, value, rdata);
        apb_access(1'b0, {idx, 2'b00}, '0, rdata);
        if (rdata !== value)
        begin
            $error("register %0d read-back: expected %h, got %h", idx, value, rdata);
            sb.errors++;
        end
        sb.load_register(idx, value);
        reg_writes++;
    endtask

    task automatic directed_steps();
        // Zero and negative rates leave the empty tank alone.
        send_step(inflow_of(32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_step(inflow_of(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000));
        send_step(inflow_of(32'hFFFF_FFFF, $urandom(), $urandom(), $urandom()));
        // The first real inflow lands in an empty tank and is taken as it is.
        send_step(inflow_of(32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000));
        send_step(inflow_of(32'h0001_0000, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF));
        send_step(inflow_of(32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001));
        send_step(inflow_of(32'h0000_0001, $urandom(), $urandom(), $urandom()));
        // With the shortest step, small rates truncate to no incoming volume.
        set_register(REG_TIME_STEP, 32'h0000_0001);
        send_step(inflow_of(32'h0000_0001, $urandom(), $urandom(), $urandom()));
        send_step(inflow_of(32'h0000_FFFF, $urandom(), $urandom(), $urandom()));
        send_step(inflow_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_step(inflow_of(32'h0001_0000, $urandom(), $urandom(), $urandom()));
        set_register(REG_TIME_STEP, 32'h0000_0000);
        send_step(inflow_of(32'h7FFF_FFFF, $urandom(), $urandom(), $urandom()));
        // A zero capacity flags overflow even on a step that changes nothing.
        set_register(REG_MAX_VOLUME, 32'h0000_0000);
        set_register(REG_TIME_STEP, TIME_STEP_RESET);
        send_step(inflow_of(32'h0000_0000, $urandom(), $urandom(), $urandom()));
        send_step(inflow_of(32'h0003_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000));
        set_register(REG_MAX_VOLUME, 32'hFFFF_FFFF);
        send_step(inflow_of(32'h0000_0100, $urandom(), $urandom(), $urandom()));
        set_register(REG_TIME_STEP, 32'hFFFF_FFFF);
        send_step(inflow_of(32'h0000_0001, $urandom(), $urandom(), $urandom()));
        send_step(inflow_of(32'h0000_0002, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000));
        set_register(REG_MAX_VOLUME, MAX_VOLUME_RESET);
        set_register(REG_TIME_STEP, TIME_STEP_RESET);
        send_step(inflow_of(32'h0001_0000, $urandom(), $urandom(), $urandom()));
    endtask

    initial
    begin : result_sink
        int          hold_left;
        tank_state_t got;
        hold_left         = 0;
        step_out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (step_out_if.valid && step_out_if.ready)
            begin
                got.volume      = step_out_if.tank_volume;
                got.temperature = step_out_if.tank_temperature;
                got.conc_a      = step_out_if.tank_conc_a;
                got.conc_b      = step_out_if.tank_conc_b;
                got.overflow    = step_out_if.overflow;
                sb.check_result(got);
            end
            if (long_hold_go)
            begin
                hold_left    = LONG_HOLD_CYCLES;
                long_hold_go = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                step_out_if.ready <= 1'b0;
            end
            else
                step_out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        int waited;
        sb            = new();
        send_idle_pct = 7;
        recv_idle_pct = 47;
        long_hold_go  = 1'b0;
        reg_writes    = 0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        step_in_if.valid              = 1'b0;
        step_in_if.inflow_rate        = '0;
        step_in_if.inflow_temperature = '0;
        step_in_if.inflow_conc_a      = '0;
        step_in_if.inflow_conc_b      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_steps();

        // The shortest step lets every rate bit toggle while the tank grows slowly.
        set_register(REG_TIME_STEP, 32'h0000_0001);
        set_register(REG_MAX_VOLUME, sb.volume + $urandom_range(32'h00FF_FFFF));
        run_random(400, 1, 32'h7FFF_FFFF);

        send_idle_pct = 47;
        recv_idle_pct = 7;
        set_register(REG_TIME_STEP, TIME_STEP_RESET);
        set_register(REG_MAX_VOLUME, sb.volume + $urandom_range(32'h01FF_FFFF));
        // The result side stalls for a long stretch while steps keep coming.
        long_hold_go = 1'b1;
        run_random(400, 1, 32'h0002_0000);

        set_register(REG_TIME_STEP, $urandom_range(32'h0004_0000, 1));
        set_register(REG_MAX_VOLUME, sb.volume + $urandom_range(32'h03FF_FFFF));
        run_random(200, 1, 32'h0000_FFFF);
        settle_tank();
        run_random(200, 1, 32'h0000_FFFF);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_register(REG_TIME_STEP, 32'h0000_0000);
        set_register(REG_MAX_VOLUME, 32'h0000_0000);
        run_random(20, 1, 32'h7FFF_FFFF);
        set_register(REG_TIME_STEP, 32'hFFFF_FFFF);
        set_register(REG_MAX_VOLUME, sb.volume + $urandom_range(32'h01FF_FFFF));
        run_random(100, 1, 8);

        // Large steps drive the tank into saturation, where the weights are halved.
        set_register(REG_MAX_VOLUME, 32'hFFFF_FFFF);
        set_register(REG_TIME_STEP, $urandom());
        run_random(150, 1, 32'h7FFF_FFFF);
        set_register(REG_MAX_VOLUME, 32'hFFFF_FFFE);
        set_register(REG_TIME_STEP, $urandom() | 32'h0001_0000);
        run_random(150, 1, 32'h7FFF_FFFF);

        step_in_if.valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d tank states never arrived", sb.pending());
            sb.errors += sb.pending();
        end

        $display("Checked %0d tank steps: %0d mixed inflow into the tank, %0d flagged overflow.",
                 sb.steps, sb.mixed_steps, sb.overflow_steps);
        $display("Used %0d register writes, three idling modes, a long result stall and a drain.",
                 reg_writes);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Several times the slowest correct run.
    initial
    begin : watchdog
        #15_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
